/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the receive tracker RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ota_brt_pkg.sv */
// ---------------------------------------------------------------------------
// ota_brt_pkg
// Shared constants and types of the firmware-chunk receive tracker.
// ---------------------------------------------------------------------------
package ota_brt_pkg;

  localparam int NUM_BLOCKS = 1024;

  // Bitmap stored as rows of ROW_W bits, one valid flag per row.
  localparam int ROW_W  = (NUM_BLOCKS < 32) ? NUM_BLOCKS : 32;
  localparam int ROWS   = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int BIT_W  = (ROW_W > 1) ? $clog2(ROW_W) : 1;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Request class decided by the front end.
  localparam logic KIND_NACK  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // Acknowledgement codes.
  localparam logic ACK  = 1'b0;
  localparam logic NACK = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] chunk_index;
    logic [15:0] chunk_total;
    logic        store_ok;
  } brt_item_t;

endpackage

/* hw/rtl/ota_brt_front.sv */
// ---------------------------------------------------------------------------
// ota_brt_front
// Holds the magic register, drops bad requests and classifies the rest.
// ---------------------------------------------------------------------------
module ota_brt_front import ota_brt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_length_ok,
  input  logic [15:0] in_magic,
  input  logic [15:0] in_chunk_index,
  input  logic [15:0] in_chunk_total,
  input  logic [15:0] in_received_crc,
  input  logic [15:0] in_computed_crc,
  input  logic        in_store_ok,
  input  logic        q_full,
  output logic        q_push,
  output brt_item_t   q_item
);

  logic [15:0] magic_r;
  logic [15:0] magic_nxt;
  logic        keep;
  logic        in_range;

  assign cfg_ready = 1'b1;
  assign magic_nxt = (cfg_valid && cfg_ready) ? cfg_data : magic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
    end else begin
      magic_r <= magic_nxt;
    end
  end

  assign in_full  = q_full;
  assign keep     = in_length_ok && (in_magic == magic_r);
  assign in_range = ({1'b0, in_chunk_index} < 17'(NUM_BLOCKS));
  // dropped requests are accepted but never reach the queue
  assign q_push   = in_push && !q_full && keep;

  always_comb begin
    q_item.chunk_index = in_chunk_index;
    q_item.chunk_total = in_chunk_total;
    q_item.store_ok    = in_store_ok;
    if ((in_received_crc != in_computed_crc) || !in_range) begin
      q_item.kind = KIND_NACK;
    end else begin
      q_item.kind = KIND_CHECK;
    end
  end

endmodule

/* hw/rtl/ota_brt_queue.sv */
// ---------------------------------------------------------------------------
// ota_brt_queue
// Short FIFO of classified requests between front and back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ota_brt_queue import ota_brt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  brt_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output brt_item_t pop_item
);

  brt_item_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QAW'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QAW'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  `ASSERT_CLK(a_q_cnt_bound, cnt_r <= (QAW+1)'(QDEPTH), "queue count overrun")

endmodule

/* hw/rtl/ota_brt_back.sv */
// ---------------------------------------------------------------------------
// ota_brt_back
// Bitmap read-modify-write, stored count and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ota_brt_back import ota_brt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  brt_item_t   q_item,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_chunk_echo,
  output logic        out_ack_status,
  output logic        out_write_payload,
  output logic        out_image_complete
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WB   = 1'b1;

  logic              state_r, state_nxt;
  brt_item_t         item_r;
  logic [ROW_W-1:0]  mem [ROWS];
  logic [ROW_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [ROWS-1:0]   row_vld_r, row_vld_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [15:0]       out_chunk_r;
  logic              out_nack_r, out_wr_r, out_done_r;

  logic [ROW_AW-1:0] rd_row, wr_row;
  logic [BIT_W-1:0]  wr_bit;
  logic [ROW_W-1:0]  row_cur, row_new;
  logic              seen, wr_en, nack, done, slot_free, finish;
  logic [16:0]       cnt_inc;

  assign rd_row    = ROW_AW'(q_item.chunk_index >> BIT_W);
  assign wr_row    = ROW_AW'(item_r.chunk_index >> BIT_W);
  assign wr_bit    = BIT_W'(item_r.chunk_index);
  assign slot_free = !out_vld_r || out_pop;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign finish    = (state_r == S_WB) && slot_free;

  // a row never written since reset reads as zero
  assign row_cur = rd_vld_r ? rd_data_r : '0;
  assign seen    = row_cur[wr_bit];

  always_comb begin
    row_new         = row_cur;
    row_new[wr_bit] = 1'b1;
  end

  assign wr_en   = finish && (item_r.kind == KIND_CHECK) && !seen && item_r.store_ok;
  assign cnt_inc = 17'(cnt_r) + 17'd1;
  assign done    = wr_en && (cnt_inc == {1'b0, item_r.chunk_total});

  always_comb begin
    if (item_r.kind == KIND_NACK) begin
      nack = NACK;
    end else if (seen) begin
      nack = ACK;
    end else if (item_r.store_ok) begin
      nack = ACK;
    end else begin
      nack = NACK;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    row_vld_nxt = row_vld_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r && !out_pop;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (finish) begin
          state_nxt   = S_IDLE;
          out_vld_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (wr_en) begin
      row_vld_nxt[wr_row] = 1'b1;
      cnt_nxt             = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      row_vld_r <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_vld_r <= row_vld_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // bitmap: read on pop, written back from S_WB once the result slot is free
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data_r <= mem[rd_row];
      rd_vld_r  <= row_vld_r[rd_row];
      item_r    <= q_item;
    end
    if (wr_en) begin
      mem[wr_row] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_chunk_r <= item_r.chunk_index;
      out_nack_r  <= nack;
      out_wr_r    <= wr_en;
      out_done_r  <= done;
    end
  end

  assign out_empty          = !out_vld_r;
  assign out_chunk_echo     = out_chunk_r;
  assign out_ack_status     = out_nack_r;
  assign out_write_payload  = out_wr_r;
  assign out_image_complete = out_done_r;

  `ASSERT_CLK(a_cnt_step, wr_en |=> (cnt_r == $past(cnt_r) + 1'b1), "count not bumped")
  `ASSERT_CLK(a_row_marked, wr_en |=> row_vld_r[$past(wr_row)], "row flag not set")
  `ASSERT_CLK(a_done_needs_wr, (out_vld_r && out_done_r) |-> (out_wr_r && !out_nack_r),
              "completion without store")

endmodule

/* hw/rtl/ota_block_receive_tracker.sv */
// ---------------------------------------------------------------------------
// ota_block_receive_tracker
// Firmware-chunk receive tracker: bitmap of stored blocks and ACK/NACK.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue (in_push/in_full): one decoded packet header per request.
//   Headers with a bad length or wrong magic word are taken and dropped.
//   Every other header yields one result on the output queue
//   (out_empty/out_pop): chunk echo, ACK/NACK, payload-write strobe and
//   image-complete flag, in arrival order.
//   cfg_valid/cfg_ready/cfg_data write the expected magic word; cfg_ready is
//   always high. Write it only while the block is idle.
// Timing:
//   Front end classifies in the accept cycle and pushes into a 2-entry queue.
//   Back end takes one request at a time: it reads the bitmap row on pop,
//   then does the modify/write-back and result load in S_WB once the result
//   slot is free. No new request is popped before the last has finished.
//   On its way a request is held in the queue, item_r and the result register.
// Reset (rst_n, synchronous, active low) clears the queue, count, magic word
//   and the per-row flags, so the whole bitmap reads as zero at once.
// A stalled receiver holds the result register; the back end waits, the
//   queue fills and in_full then pushes back on the sender.
// ---------------------------------------------------------------------------
module ota_block_receive_tracker import ota_brt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // request side
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_length_ok,
  input  logic [15:0] in_magic,
  input  logic [15:0] in_chunk_index,
  input  logic [15:0] in_chunk_total,
  input  logic [15:0] in_received_crc,
  input  logic [15:0] in_computed_crc,
  input  logic        in_store_ok,
  // result side
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_chunk_echo,
  output logic        out_ack_status,
  output logic        out_write_payload,
  output logic        out_image_complete
);

  // front -> queue
  logic      fq_push;
  logic      fq_full;
  brt_item_t fq_item;
  // queue -> back
  logic      qb_pop;
  logic      qb_empty;
  brt_item_t qb_item;

  ota_brt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_length_ok    (in_length_ok),
    .in_magic        (in_magic),
    .in_chunk_index  (in_chunk_index),
    .in_chunk_total  (in_chunk_total),
    .in_received_crc (in_received_crc),
    .in_computed_crc (in_computed_crc),
    .in_store_ok     (in_store_ok),
    .q_full          (fq_full),
    .q_push          (fq_push),
    .q_item          (fq_item)
  );

  ota_brt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (fq_full),
    .pop       (qb_pop),
    .empty     (qb_empty),
    .pop_item  (qb_item)
  );

  ota_brt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (qb_empty),
    .q_item             (qb_item),
    .q_pop              (qb_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_chunk_echo     (out_chunk_echo),
    .out_ack_status     (out_ack_status),
    .out_write_payload  (out_write_payload),
    .out_image_complete (out_image_complete)
  );

endmodule

/* tb/tb_ota_block_receive_tracker.sv */
// ---------------------------------------------------------------------------
// tb_ota_block_receive_tracker
// Self-checking bench for the firmware-chunk receive tracker. Packet headers
// go in through the request queue; a local tracker keeps its own bitmap,
// stored-block count and magic word, and predicts each acknowledgement. A
// receiver process pops results at random and compares them field by field.
// ---------------------------------------------------------------------------
module tb_ota_block_receive_tracker import ota_brt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_IDLE    = 17;
  // Settle margin after the last result is popped, for dropped requests.
  localparam int SETTLE_CYCLES = 10;

  // One decoded packet header, i.e. one request.
  typedef struct packed {
    logic        length_ok;
    logic [15:0] magic;
    logic [15:0] chunk_index;
    logic [15:0] chunk_total;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic        store_ok;
  } chunk_hdr_t;

  // One acknowledgement as it leaves the block.
  typedef struct packed {
    logic [15:0] chunk_echo;
    logic        ack_status;
    logic        write_payload;
    logic        image_complete;
  } chunk_ack_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_push;
  logic        in_full;
  logic        in_length_ok;
  logic [15:0] in_magic;
  logic [15:0] in_chunk_index;
  logic [15:0] in_chunk_total;
  logic [15:0] in_received_crc;
  logic [15:0] in_computed_crc;
  logic        in_store_ok;
  logic        out_empty;
  logic        out_pop;
  logic [15:0] out_chunk_echo;
  logic        out_ack_status;
  logic        out_write_payload;
  logic        out_image_complete;

  // Local copy of the tracker state.
  logic [NUM_BLOCKS-1:0] seen_map;
  logic [CNT_W-1:0]      stored_blocks;
  logic [15:0]           magic_word;

  chunk_ack_t acks_due[$];     // acknowledgements not yet popped, oldest first
  int         answered_cnt;    // accepted requests that owe an acknowledgement
  int         mismatch_cnt;
  int         cycle_cnt;
  int         hold_cnt;        // receiver hold-off still to run, in cycles
  bit         tx_gaps_on;
  bit         rx_waits_on;

  ota_block_receive_tracker u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_length_ok      (in_length_ok),
    .in_magic          (in_magic),
    .in_chunk_index    (in_chunk_index),
    .in_chunk_total    (in_chunk_total),
    .in_received_crc   (in_received_crc),
    .in_computed_crc   (in_computed_crc),
    .in_store_ok       (in_store_ok),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_chunk_echo    (out_chunk_echo),
    .out_ack_status    (out_ack_status),
    .out_write_payload (out_write_payload),
    .out_image_complete(out_image_complete)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-away guard: counts every edge, reset included.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Long receiver hold-off, counted down here so the sender can keep pushing.
  initial begin
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) hold_cnt--;
    end
  end

  // Works out the acknowledgement for one accepted request and updates the
  // local state. Returns 0 when the header is dropped without an answer.
  function automatic bit track_chunk(input chunk_hdr_t h, output chunk_ack_t a);
    a = '{h.chunk_index, NACK, 1'b0, 1'b0};
    if (!h.length_ok || h.magic != magic_word) return 1'b0;
    if (h.received_crc != h.computed_crc) begin
      a.ack_status = NACK;
    end else if (h.chunk_index >= NUM_BLOCKS) begin
      // out of range: refused, nothing touched
      a.ack_status = NACK;
    end else if (seen_map[h.chunk_index]) begin
      // duplicate: acknowledged again, no second write
      a.ack_status = ACK;
    end else if (h.store_ok) begin
      seen_map[h.chunk_index] = 1'b1;
      stored_blocks           = stored_blocks + 1'b1;
      a.ack_status            = ACK;
      a.write_payload         = 1'b1;
      // a total of zero can never match a non-zero count
      a.image_complete        = (32'(stored_blocks) == 32'(h.chunk_total));
    end
    return 1'b1;
  endfunction

  function automatic chunk_hdr_t mk_hdr(input logic len_ok, input logic [15:0] magic,
                                        input logic [15:0] idx, input logic [15:0] total,
                                        input logic [15:0] rcrc, input logic [15:0] ccrc,
                                        input logic st_ok);
    mk_hdr = '{len_ok, magic, idx, total, rcrc, ccrc, st_ok};
  endfunction

  // Mostly well-formed headers with random content; the rest is noise.
  function automatic chunk_hdr_t rand_header();
    chunk_hdr_t h;
    int         pick;
    pick           = $urandom_range(0, 99);
    h.length_ok    = 1'b1;
    h.magic        = magic_word;
    // a small hot range keeps duplicates frequent
    h.chunk_index  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 31))
                                                 : 16'($urandom_range(0, NUM_BLOCKS - 1));
    h.received_crc = 16'($urandom);
    h.computed_crc = h.received_crc;
    h.store_ok     = ($urandom_range(0, 7) != 0);
    // aim at the next count often enough to see completions
    h.chunk_total  = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'(stored_blocks + 1);
    if (pick < 10) begin
      h.computed_crc = h.received_crc ^ 16'($urandom_range(1, 65535));
    end else if (pick < 18) begin
      h.chunk_index = 16'($urandom_range(NUM_BLOCKS, 65535));
    end else if (pick < 24) begin
      h.length_ok = 1'b0;
      if ($urandom_range(0, 1)) h.magic = 16'($urandom);
    end else if (pick < 30) begin
      h.magic = magic_word ^ 16'($urandom_range(1, 65535));
    end
    return h;
  endfunction

  // Offers one request and returns at the falling edge after it is taken,
  // with in_push still high; the caller either pushes again or settles.
  task automatic push_header(input chunk_hdr_t h);
    int         gap;
    chunk_ack_t a;
    gap = tx_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_length_ok    <= h.length_ok;
    in_magic        <= h.magic;
    in_chunk_index  <= h.chunk_index;
    in_chunk_total  <= h.chunk_total;
    in_received_crc <= h.received_crc;
    in_computed_crc <= h.computed_crc;
    in_store_ok     <= h.store_ok;
    in_push         <= 1'b1;
    do @(posedge clk); while (in_full !== 1'b0);
    if (track_chunk(h, a)) begin
      acks_due.push_back(a);
      answered_cnt++;
    end
    @(negedge clk);
  endtask

  // Drop the request line and wait until the block has gone quiet.
  task automatic settle();
    in_push <= 1'b0;
    while (acks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_magic(input logic [15:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    magic_word = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Runs with the reset magic word (zero) before any register write.
  task automatic test_corner_cases();
    push_header(mk_hdr(1'b0, 16'h0000, 16'd3, 16'd1, 16'h1234, 16'h1234, 1'b1)); // bad length
    push_header(mk_hdr(1'b1, 16'hFFFF, 16'd3, 16'd1, 16'h1234, 16'h1234, 1'b1)); // wrong magic
    push_header(mk_hdr(1'b0, 16'hFFFF, 16'd3, 16'd1, 16'h1234, 16'h1234, 1'b1)); // both bad
    push_header(mk_hdr(1'b1, 16'h0000, 16'd0, 16'd1, 16'hFFFF, 16'h0000, 1'b1)); // CRC mismatch
    push_header(mk_hdr(1'b1, 16'h0000, 16'(NUM_BLOCKS), 16'd1, 16'hAAAA, 16'hAAAA, 1'b1));
    push_header(mk_hdr(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
    push_header(mk_hdr(1'b1, 16'h0000, 16'd0, 16'd1, 16'h5555, 16'h5555, 1'b0)); // store fails
    push_header(mk_hdr(1'b1, 16'h0000, 16'd0, 16'd0, 16'h5555, 16'h5555, 1'b1)); // total zero
    push_header(mk_hdr(1'b1, 16'h0000, 16'd0, 16'd1, 16'h5555, 16'h5555, 1'b1)); // duplicate
    push_header(mk_hdr(1'b1, 16'h0000, 16'(NUM_BLOCKS - 1), 16'd2, 16'hFFFF, 16'hFFFF, 1'b1));
    push_header(mk_hdr(1'b1, 16'h0000, 16'(NUM_BLOCKS - 1), 16'd2, 16'h0F0F, 16'h0F0F, 1'b0));
    push_header(mk_hdr(1'b1, 16'h0000, 16'(NUM_BLOCKS - 1), 16'd2, 16'h0000, 16'h0001, 1'b1));
    push_header(mk_hdr(1'b1, 16'h0000, 16'd512, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
    push_header(mk_hdr(1'b1, 16'h0000, 16'd1, 16'd4, 16'h8001, 16'h8001, 1'b1));   // completes
    push_header(mk_hdr(1'b1, 16'h0000, 16'd2, 16'd4, 16'h7FFE, 16'h7FFE, 1'b1));   // past total
    settle();
  endtask

  task automatic test_random_headers(input logic [15:0] m, input int n);
    int goal;
    write_magic(m);
    goal = answered_cnt + n;
    while (answered_cnt < goal) push_header(rand_header());
    settle();
  endtask

  // Back-to-back requests with the receiver always ready.
  task automatic test_full_rate(input logic [15:0] m, input int n);
    int goal;
    write_magic(m);
    tx_gaps_on  = 1'b0;
    rx_waits_on = 1'b0;
    goal = answered_cnt + n;
    while (answered_cnt < goal) push_header(rand_header());
    settle();
    tx_gaps_on  = 1'b1;
    rx_waits_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps going, so in_full must rise.
  task automatic test_back_pressure(input int n);
    int goal;
    tx_gaps_on = 1'b0;
    hold_cnt   = 150;
    goal = answered_cnt + n;
    while (answered_cnt < goal) push_header(rand_header());
    settle();
    tx_gaps_on = 1'b1;
  endtask

  // Receiver: pops after a random wait per result and checks each one.
  initial begin
    chunk_ack_t exp_ack;
    int         wait_left;
    out_pop   = 1'b0;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && out_empty === 1'b0) begin
        if (acks_due.size() == 0) begin
          $error("unexpected result: chunk_echo %0d", out_chunk_echo);
          mismatch_cnt++;
        end else begin
          exp_ack = acks_due.pop_front();
          if (out_chunk_echo !== exp_ack.chunk_echo) begin
            $error("chunk_echo: expected %0d, actual %0d", exp_ack.chunk_echo, out_chunk_echo);
            mismatch_cnt++;
          end
          if (out_ack_status !== exp_ack.ack_status) begin
            $error("ack_status: expected %0d, actual %0d", exp_ack.ack_status, out_ack_status);
            mismatch_cnt++;
          end
          if (out_write_payload !== exp_ack.write_payload) begin
            $error("write_payload: expected %0d, actual %0d",
                   exp_ack.write_payload, out_write_payload);
            mismatch_cnt++;
          end
          if (out_image_complete !== exp_ack.image_complete) begin
            $error("image_complete: expected %0d, actual %0d",
                   exp_ack.image_complete, out_image_complete);
            mismatch_cnt++;
          end
        end
        wait_left = rx_waits_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_pop <= 1'b0;
      end else if (wait_left > 0) begin
        out_pop <= 1'b0;
        wait_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Main sequence: reset once, then the tests in turn.
  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    in_push         = 1'b0;
    in_length_ok    = 1'b0;
    in_magic        = '0;
    in_chunk_index  = '0;
    in_chunk_total  = '0;
    in_received_crc = '0;
    in_computed_crc = '0;
    in_store_ok     = 1'b0;
    seen_map        = '0;
    stored_blocks   = '0;
    magic_word      = '0;
    answered_cnt    = 0;
    mismatch_cnt    = 0;
    tx_gaps_on      = 1'b1;
    rx_waits_on     = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_cases();
    test_random_headers(16'hFFFF, 180);
    test_full_rate(16'h0000, 120);
    test_random_headers(16'($urandom), 130);
    test_back_pressure(60);

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
